/* rtl/rgb_led_strip_serializer_defines.svh */
// Assertion macros shared by the LED strip serializer RTL.
`ifndef RGB_LED_STRIP_SERIALIZER_DEFINES_SVH
`define RGB_LED_STRIP_SERIALIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define RLSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RLSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RLSS_ASSERT_IMP(lbl, ante, cons)
`define RLSS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/rlss_pkg.sv */
// Shared types, codes and helpers for the LED strip serializer.
`timescale 1ns / 1ps
package rlss_pkg;

	localparam int PIXEL_W = 24;
	localparam int LANE_W  = 8;
	localparam int LANES   = PIXEL_W / LANE_W;
	localparam int BIT_LAST = PIXEL_W - 1;

	localparam logic [10:0] LED_COUNT_RST   = 11'd1024;
	localparam logic [15:0] LATCH_TICKS_RST = 16'd500;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_FILL  = 3'd1,
		ACT_READ  = 3'd2,
		ACT_START = 3'd3,
		ACT_TICK  = 3'd4
	} action_t;

	localparam logic [0:0] CFG_LED_COUNT   = 1'b0;
	localparam logic [0:0] CFG_LATCH_TICKS = 1'b1;

	// Saturate a signed 16-bit colour to 0..255.
	function automatic logic [LANE_W-1:0] clamp_colour(input logic signed [15:0] v);
		logic [LANE_W-1:0] r;
		if (v[15])
			r = '0;
		else if (v[14:8] != 7'd0)
			r = '1;
		else
			r = v[7:0];
		return r;
	endfunction

endpackage

/* rtl/rlss_frame_ram.sv */
// Frame store: one word per LED, byte-lane writes and registered read.
`timescale 1ns / 1ps
module rlss_frame_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [rlss_pkg::LANES-1:0]   wr_lanes,
	input  logic [AW-1:0]                wr_addr,
	input  logic [rlss_pkg::PIXEL_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic [rlss_pkg::PIXEL_W-1:0] rd_data
);
	import rlss_pkg::*;

	logic [PIXEL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (wr_en && wr_lanes[l]) begin
				mem[wr_addr][l*LANE_W +: LANE_W] <= wr_data[l*LANE_W +: LANE_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/rgb_led_strip_serializer.sv */
// Top level of the LED strip serializer: command decode, frame sweep and bit shifter.
//
// Usage: commands arrive on the input channel (in_valid / in_stall) and every
// accepted command returns exactly one result on the output channel
// (out_valid / out_stall). A transfer happens when valid is high and stall low.
// Each result is registered and appears in the cycle after its command is taken;
// a command can be taken every cycle while the output side keeps up and no fill
// runs, so tick commands drive the strip at one bit phase per cycle, 48 ticks per
// LED plus latch_ticks. A fill command stalls the input while the frame store is
// swept one entry per cycle, entries 0 to min(max(led_count,1),MAX_LEDS)-1; its
// result is already out. A read answers from the registered frame store port, in
// the cycle after it is taken. The serializer prefetches the next LED's word
// during the first bit of the current one, so ticks never wait on the store.
// Reset clears the line levels and the serializer and restores led_count 1024
// and latch_ticks 500; frame store contents stay undefined until written.
// While the receiver stalls, the pending result holds and no new command is
// taken. Configuration is written through cfg_we / cfg_index / cfg_wdata.
`timescale 1ns / 1ps
`include "rgb_led_strip_serializer_defines.svh"
module rgb_led_strip_serializer #(
	parameter int MAX_LEDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [9:0]  led_index,
	input  logic [2:0]  channel_mask,
	input  logic signed [15:0] red_in,
	input  logic signed [15:0] green_in,
	input  logic signed [15:0] blue_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        clk_line,
	output logic        data_line,
	output logic        busy_res,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out
);
	import rlss_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int CW = $clog2(MAX_LEDS + 1);
	localparam int NW = (CW > 11) ? CW : 11;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_SEND,
		MODE_LATCH,
		MODE_FILL
	} mode_t;

	mode_t         mode_q;
	logic [10:0]   led_count_q;
	logic [15:0]   latch_ticks_q;
	logic [NW-1:0] send_led_q;
	logic [NW-1:0] fill_idx_q;
	logic [4:0]    bit_pos_q;
	logic          clock_phase_q;
	logic [15:0]   latch_count_q;
	logic          clk_q;
	logic          data_q;
	logic          out_valid_q;
	logic          out_busy_q;
	logic          out_rd_q;
	logic [PIXEL_W-1:0] shift_q;
	logic [PIXEL_W-1:0] fill_word_q;
	logic [PIXEL_W-1:0] rd_word;

	logic          in_acc;
	logic [NW-1:0] led_ext;
	logic [NW-1:0] n_act;
	logic [NW-1:0] idx_ext;
	logic          idx_ok;
	logic [NW-1:0] send_next;
	logic [NW-1:0] fill_next;
	logic          is_idle_cmd;
	logic          is_tick;
	logic [PIXEL_W-1:0] in_word;
	logic          wr_en;
	logic [LANES-1:0] wr_lanes;
	logic [AW-1:0] wr_addr;
	logic [PIXEL_W-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	assign in_stall  = (out_valid_q && out_stall) || (mode_q == MODE_FILL);
	assign in_acc    = in_valid && !in_stall;
	assign led_ext   = NW'(led_count_q);
	assign n_act     = (led_count_q == 11'd0) ? NW'(1) :
			((led_ext > NW'(MAX_LEDS)) ? NW'(MAX_LEDS) : led_ext);
	assign idx_ext   = NW'(led_index);
	assign idx_ok    = idx_ext < n_act;
	assign send_next = send_led_q + NW'(1);
	assign fill_next = fill_idx_q + NW'(1);
	assign is_tick   = in_acc && (action == ACT_TICK);
	assign is_idle_cmd = in_acc && (mode_q == MODE_IDLE) && (action != ACT_TICK);
	assign in_word   = {clamp_colour(red_in), clamp_colour(green_in), clamp_colour(blue_in)};

	always_comb begin
		wr_en    = 1'b0;
		wr_lanes = '0;
		wr_addr  = idx_ext[AW-1:0];
		wr_data  = in_word;
		rd_en    = 1'b0;
		rd_addr  = idx_ext[AW-1:0];
		if (mode_q == MODE_FILL) begin
			wr_en    = 1'b1;
			wr_lanes = '1;
			wr_addr  = fill_idx_q[AW-1:0];
			wr_data  = fill_word_q;
		end else if (is_idle_cmd) begin
			case (action)
				ACT_WRITE: begin
					wr_en    = idx_ok;
					wr_lanes = {channel_mask[0], channel_mask[1], channel_mask[2]};
				end
				ACT_READ: rd_en = 1'b1;
				ACT_START: begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
				default: ;
			endcase
		end else if (is_tick && mode_q == MODE_SEND && !clock_phase_q
				&& bit_pos_q == 5'd0) begin
			rd_en   = 1'b1;
			rd_addr = send_next[AW-1:0];
		end
	end

	rlss_frame_ram #(
		.DEPTH(MAX_LEDS),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_lanes(wr_lanes),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_word)
	);

	always_ff @(posedge clk) begin
		if (is_tick && mode_q == MODE_SEND && !clock_phase_q) begin
			shift_q <= (bit_pos_q == 5'd0) ? {rd_word[PIXEL_W-2:0], 1'b0} :
					{shift_q[PIXEL_W-2:0], 1'b0};
		end
		if (is_idle_cmd && action == ACT_FILL) begin
			fill_word_q <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			led_count_q   <= LED_COUNT_RST;
			latch_ticks_q <= LATCH_TICKS_RST;
			send_led_q    <= '0;
			fill_idx_q    <= '0;
			bit_pos_q     <= '0;
			clock_phase_q <= 1'b0;
			latch_count_q <= '0;
			clk_q         <= 1'b0;
			data_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			out_busy_q    <= 1'b0;
			out_rd_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LED_COUNT:   led_count_q   <= cfg_wdata[10:0];
					CFG_LATCH_TICKS: latch_ticks_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (mode_q == MODE_FILL) begin
				if (fill_next >= n_act) begin
					mode_q <= MODE_IDLE;
				end
				fill_idx_q <= fill_next;
			end

			if (in_acc) begin
				out_valid_q <= 1'b1;
				out_busy_q  <= (is_tick && (mode_q inside {MODE_SEND, MODE_LATCH})) ||
						(is_idle_cmd && action == ACT_START);
				out_rd_q    <= is_idle_cmd && action == ACT_READ && idx_ok;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (is_tick) begin
				case (mode_q)
					MODE_SEND: begin
						if (!clock_phase_q) begin
							clk_q         <= 1'b0;
							data_q        <= (bit_pos_q == 5'd0) ? rd_word[BIT_LAST] :
									shift_q[BIT_LAST];
							clock_phase_q <= 1'b1;
						end else begin
							clk_q         <= 1'b1;
							clock_phase_q <= 1'b0;
							if (bit_pos_q == 5'(BIT_LAST)) begin
								bit_pos_q <= '0;
								if (send_next >= n_act) begin
									send_led_q    <= '0;
									mode_q        <= MODE_LATCH;
									latch_count_q <= (latch_ticks_q == 16'd0) ? 16'd1 :
											latch_ticks_q;
								end else begin
									send_led_q <= send_next;
								end
							end else begin
								bit_pos_q <= bit_pos_q + 5'd1;
							end
						end
					end
					MODE_LATCH: begin
						clk_q      <= 1'b0;
						if (latch_count_q != 16'd0) begin
							latch_count_q <= latch_count_q - 16'd1;
						end
						if (latch_count_q <= 16'd1) begin
							mode_q <= MODE_IDLE;
						end
					end
					default: ;
				endcase
			end else if (is_idle_cmd) begin
				case (action)
					ACT_FILL: begin
						mode_q     <= MODE_FILL;
						fill_idx_q <= '0;
					end
					ACT_START: begin
						mode_q        <= MODE_SEND;
						send_led_q    <= '0;
						bit_pos_q     <= '0;
						clock_phase_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign clk_line  = clk_q;
	assign data_line = data_q;
	assign busy_res  = out_busy_q;
	assign red_out   = out_rd_q ? rd_word[2*LANE_W +: LANE_W] : '0;
	assign green_out = out_rd_q ? rd_word[LANE_W +: LANE_W] : '0;
	assign blue_out  = out_rd_q ? rd_word[0 +: LANE_W] : '0;

	`RLSS_ASSERT_IMP(a_fill_blocks_input, mode_q == MODE_FILL, in_stall)
	`RLSS_ASSERT_IMP(a_high_phase_clk_low, mode_q == MODE_SEND && clock_phase_q, !clk_q)
	`RLSS_ASSERT_NXT(a_result_follows, in_acc, out_valid)
	`RLSS_ASSERT_IMP(a_bit_pos_range, mode_q == MODE_SEND, bit_pos_q <= 5'(BIT_LAST))

endmodule
